/* src/ipv4u_pkg.sv */
`default_nettype none
package ipv4u_pkg;

	// statistics window, in packet starts
	localparam int REPORT_WINDOW = 100;

	// header field codes
	localparam logic [3:0] IP_VERSION_4   = 4'd4;
	localparam logic [3:0] MIN_HDR_WORDS  = 4'd5;
	localparam logic [7:0] PROTO_UDP      = 8'd17;
	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [15:0] INDEX_MAX     = 16'hFFFF;
	localparam logic [15:0] SUM_GOOD      = 16'hFFFF;

	// header byte positions
	localparam logic [15:0] IDX_LEN_HI = 16'd2;
	localparam logic [15:0] IDX_LEN_LO = 16'd3;
	localparam logic [15:0] IDX_PROTO  = 16'd9;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	// item held in the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	// result offered to the output register
	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] value;
		logic       payload_end;
	} res_t;

endpackage
`default_nettype wire

/* src/ipv4u_in_if.sv */
`default_nettype none
interface ipv4u_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* src/ipv4u_out_if.sv */
`default_nettype none
interface ipv4u_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] value;
	logic       payload_end;

	modport source(output valid, output kind, output value, output payload_end, input ready);
	modport sink(input valid, input kind, input value, input payload_end, output ready);
endinterface
`default_nettype wire

/* src/ipv4u_input_stage.sv */
`default_nettype none
module ipv4u_input_stage (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ipv4u_in_if.sink         pkt,
	input  wire logic        adv,
	output ipv4u_pkg::item_t item
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// take a new item when the register is empty or moving on
	assign pkt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			data_s1 <= pkt.data_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	assign item.valid     = valid_s1;
	assign item.data_byte = data_s1;
	assign item.last_byte = last_s1;

endmodule
`default_nettype wire

/* src/ipv4u_parser.sv */
`default_nettype none
module ipv4u_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  ipv4u_pkg::item_t item,
	input  wire logic        adv,
	output ipv4u_pkg::res_t  res
);

	localparam logic [6:0] WINDOW = 7'(ipv4u_pkg::REPORT_WINDOW);
	localparam logic [6:0] ERR_MAX = 7'h7F;

	logic        report_enable_q;
	logic [15:0] byte_index_q;
	logic [3:0]  header_words_q;
	logic [15:0] total_length_q;
	logic [20:0] word_sum_q;
	logic [7:0]  high_byte_hold_q;
	logic [7:0]  protocol_number_q;
	logic        drop_packet_q;
	logic [6:0]  packet_count_q;
	logic [6:0]  error_count_q;

	logic [15:0] byte_index_d;
	logic [3:0]  header_words_d;
	logic [15:0] total_length_d;
	logic [20:0] word_sum_d;
	logic [7:0]  high_byte_hold_d;
	logic [7:0]  protocol_number_d;
	logic        drop_packet_d;
	logic [6:0]  packet_count_d;
	logic [6:0]  error_count_d;
	logic        fire;

	assign fire = item.valid && adv;

	// one byte step of the parser
	always_comb begin
		logic [7:0]  b;
		logic [15:0] i;
		logic [15:0] hdr_bytes;
		logic [16:0] fold1;
		logic [16:0] fold2;
		b = item.data_byte;
		i = byte_index_q;
		header_words_d    = header_words_q;
		total_length_d    = total_length_q;
		word_sum_d        = word_sum_q;
		high_byte_hold_d  = high_byte_hold_q;
		protocol_number_d = protocol_number_q;
		drop_packet_d     = drop_packet_q;
		packet_count_d    = packet_count_q;
		error_count_d     = error_count_q;
		res.valid       = 1'b0;
		res.kind        = ipv4u_pkg::KIND_PAYLOAD;
		res.value       = b;
		res.payload_end = 1'b0;

		// packet start: header checks and periodic report
		if (i == 16'd0) begin
			word_sum_d        = '0;
			high_byte_hold_d  = '0;
			total_length_d    = '0;
			protocol_number_d = '0;
			header_words_d    = b[3:0];
			drop_packet_d     = (b[7:4] != ipv4u_pkg::IP_VERSION_4)
				|| (b[3:0] < ipv4u_pkg::MIN_HDR_WORDS);
			if (!drop_packet_d && report_enable_q) begin
				packet_count_d = packet_count_q + 7'd1;
				if (packet_count_d >= WINDOW) begin
					res.valid      = item.valid;
					res.kind       = ipv4u_pkg::KIND_REPORT;
					res.value      = (error_count_q >= WINDOW) ? 8'd0
						: {1'b0, WINDOW - error_count_q};
					packet_count_d = '0;
					error_count_d  = '0;
				end
			end
		end

		hdr_bytes = {10'd0, header_words_d, 2'b00};
		fold1 = {12'd0, word_sum_d[20:16]} + {1'b0, word_sum_d[15:0]};
		fold2 = 17'd0;

		if (!drop_packet_d) begin
			if (i < hdr_bytes) begin
				// header bytes: fields and running sum
				if (i == ipv4u_pkg::IDX_LEN_HI) total_length_d = {b, 8'd0};
				if (i == ipv4u_pkg::IDX_LEN_LO) total_length_d = total_length_d | {8'd0, b};
				if (i == ipv4u_pkg::IDX_PROTO) protocol_number_d = b;
				if (!i[0]) begin
					high_byte_hold_d = b;
				end else begin
					word_sum_d = word_sum_q + {5'd0, high_byte_hold_q, b};
				end
				// end of header: checksum and protocol
				fold1 = {12'd0, word_sum_d[20:16]} + {1'b0, word_sum_d[15:0]};
				fold2 = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
				if (i == hdr_bytes - 16'd1) begin
					if (fold2[15:0] != ipv4u_pkg::SUM_GOOD) begin
						if (error_count_d < ERR_MAX) error_count_d = error_count_d + 7'd1;
						drop_packet_d = 1'b1;
					end else if (protocol_number_d != ipv4u_pkg::PROTO_UDP) begin
						drop_packet_d = 1'b1;
					end
				end
			end else if ((i >= hdr_bytes + ipv4u_pkg::UDP_HDR_BYTES)
					&& (i < total_length_q) && (i < ipv4u_pkg::INDEX_MAX)) begin
				// udp payload byte
				res.valid       = item.valid;
				res.kind        = ipv4u_pkg::KIND_PAYLOAD;
				res.value       = b;
				res.payload_end = item.last_byte || (i == total_length_q - 16'd1);
			end
		end

		// byte position and end of packet
		if (item.last_byte) begin
			byte_index_d  = '0;
			drop_packet_d = 1'b0;
		end else if (byte_index_q < ipv4u_pkg::INDEX_MAX) begin
			byte_index_d = byte_index_q + 16'd1;
		end else begin
			byte_index_d = byte_index_q;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_enable_q   <= 1'b0;
			byte_index_q      <= '0;
			header_words_q    <= '0;
			total_length_q    <= '0;
			word_sum_q        <= '0;
			high_byte_hold_q  <= '0;
			protocol_number_q <= '0;
			drop_packet_q     <= 1'b0;
			packet_count_q    <= '0;
			error_count_q     <= '0;
		end else begin
			if (cfg_we) report_enable_q <= cfg_wdata;
			if (fire) begin
				byte_index_q      <= byte_index_d;
				header_words_q    <= header_words_d;
				total_length_q    <= total_length_d;
				word_sum_q        <= word_sum_d;
				high_byte_hold_q  <= high_byte_hold_d;
				protocol_number_q <= protocol_number_d;
				drop_packet_q     <= drop_packet_d;
				packet_count_q    <= packet_count_d;
				error_count_q     <= error_count_d;
			end
		end
	end

endmodule
`default_nettype wire

/* src/ipv4u_output_stage.sv */
`default_nettype none
module ipv4u_output_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  ipv4u_pkg::res_t res,
	output logic            adv,
	ipv4u_out_if.source     res_out
);

	logic       valid_q;
	logic       kind_q;
	logic [7:0] value_q;
	logic       end_q;

	// the result register frees up when empty or taken
	assign adv = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			kind_q  <= res.kind;
			value_q <= res.value;
			end_q   <= res.payload_end;
		end
	end

	assign res_out.valid       = valid_q;
	assign res_out.kind        = kind_q;
	assign res_out.value       = value_q;
	assign res_out.payload_end = end_q;

endmodule
`default_nettype wire

/* src/ipv4_udp_payload_extractor_unit.sv */
// path: a result item is offered once its input byte has been accepted and has passed
// the input register and then the result register
// throughput: one byte per cycle while res.ready does not stall the result register, set by the
// single parser step per byte held between the input register and the result register
// reset: arst_n clears all parser state, counters and report_enable at once
`default_nettype none
module ipv4_udp_payload_extractor_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	ipv4u_in_if.sink    pkt,
	ipv4u_out_if.source res
);

	ipv4u_pkg::item_t item;
	ipv4u_pkg::res_t  res_d;
	logic             adv;

	ipv4u_input_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.adv    (adv),
		.item   (item)
	);

	ipv4u_parser u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.adv       (adv),
		.res       (res_d)
	);

	ipv4u_output_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res_d),
		.adv     (adv),
		.res_out (res)
	);

endmodule
`default_nettype wire

/* src/ipv4u_checker.sv */
`default_nettype none
module ipv4u_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       out_kind,
	input wire logic [7:0] out_value,
	input wire logic       out_end
);

	localparam logic [7:0] WINDOW = 8'(ipv4u_pkg::REPORT_WINDOW);

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind)
			&& $stable(out_value) && $stable(out_end))
		else $error("result item changed while stalled");

	// a report never marks a payload end
	a_report_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == ipv4u_pkg::KIND_REPORT) |-> !out_end)
		else $error("report item with payload end");

	// a report never exceeds the window
	a_report_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == ipv4u_pkg::KIND_REPORT) |-> out_value <= WINDOW)
		else $error("report value above window");

	// no result item right after reset
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result item valid after reset");

endmodule

bind ipv4_udp_payload_extractor_unit ipv4u_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_kind  (res.kind),
	.out_value (res.value),
	.out_end   (res.payload_end)
);
`default_nettype wire
